// ===== hdl/b64le_pkg.sv =====
package b64le_pkg;

  localparam logic [6:0] NlChar      = 7'h0A;
  localparam logic [6:0] PadChar     = 7'h3D;
  localparam logic [5:0] ResetGroups = 6'd18;
  localparam int unsigned GroupChars = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
  } out_item_t;

  // One unit of output work: up to four symbols (padded to four when any are
  // present) followed by an optional newline.
  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  nsym;
    logic        nl;
  } job_t;

  function automatic logic [6:0] sym64(input logic [5:0] v);
    logic [6:0] r;
    r = 7'h2F;
    case (v) inside
      [6'd0:6'd25]:  r = 7'd65 + {1'b0, v};
      [6'd26:6'd51]: r = 7'd71 + {1'b0, v};
      [6'd52:6'd61]: r = {1'b0, v} - 7'd4;
      6'd62:         r = 7'h2B;
      default:       r = 7'h2F;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/base64_line_encoder_unit.sv =====
// Base64 line encoder: raw bytes enter one per item (op 0) and leave as
// base64 characters, one per cycle while the output is unstalled, with a
// newline after every groups_per_line four-character groups (0 acts as 1).
// An op 1 item flushes a partial group with '=' padding and a closing
// newline; it gives nothing when no bytes are held and the line is empty.
// The input side takes an item every cycle while the job queue (QueueDepth
// entries) has room; each third byte or flush turns into one job of 1 to 5
// characters. Sustained rate is set by the single-character output port,
// which sends each three bytes as 4 or 5 characters.
// Write groups_per_line only while the block is idle.
module base64_line_encoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [5:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b64le_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64le_pkg::out_item_t out_item_o
);

  logic            push, pop, q_full, q_valid;
  b64le_pkg::job_t push_job, head_job;

  b64le_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64le_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_data_o  (head_job)
  );

  b64le_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/b64le_front.sv =====
module b64le_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  b64le_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64le_pkg::job_t   job_o
);

  logic [5:0]  gpl_q;
  logic [15:0] held_q, held_d;
  logic [1:0]  big_q, big_d;
  logic [5:0]  gol_q, gol_d;
  logic [5:0]  limit;
  logic [6:0]  count;
  logic        wrap;
  logic        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign limit      = (gpl_q == 6'd0) ? 6'd1 : gpl_q;
  assign count      = {1'b0, gol_q} + 7'd1;
  assign wrap       = count >= {1'b0, limit};

  always_comb begin
    held_d = held_q;
    big_d  = big_q;
    gol_d  = gol_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      if (!in_item_i.op) begin
        if (big_q != 2'd2) begin
          held_d = {held_q[7:0], in_item_i.data_byte};
          big_d  = big_q + 2'd1;
        end else begin
          push_o     = 1'b1;
          job_o.bits = {held_q, in_item_i.data_byte};
          job_o.nsym = 3'd4;
          job_o.nl   = wrap;
          held_d     = '0;
          big_d      = '0;
          gol_d      = wrap ? 6'd0 : count[5:0];
        end
      end else begin
        // flush: pad the partial group, close the line
        job_o.nl = 1'b1;
        case (big_q)
          2'd1: begin
            push_o     = 1'b1;
            job_o.bits = {held_q[7:0], 16'h0000};
            job_o.nsym = 3'd2;
          end
          2'd2: begin
            push_o     = 1'b1;
            job_o.bits = {held_q, 8'h00};
            job_o.nsym = 3'd3;
          end
          default: begin
            push_o = gol_q != 6'd0;
          end
        endcase
        held_d = '0;
        big_d  = '0;
        gol_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpl_q  <= b64le_pkg::ResetGroups;
      held_q <= '0;
      big_q  <= '0;
      gol_q  <= '0;
    end else begin
      if (cfg_we_i) gpl_q <= cfg_data_i;
      held_q <= held_d;
      big_q  <= big_d;
      gol_q  <= gol_d;
    end
  end

endmodule

// ===== hdl/b64le_fifo.sv =====
module b64le_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64le_pkg::job_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output b64le_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64le_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = cnt_q == CntW'(Depth);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

// ===== hdl/b64le_back.sv =====
module b64le_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  b64le_pkg::job_t      job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64le_pkg::out_item_t out_item_o
);

  logic                 out_valid_q, out_valid_d;
  b64le_pkg::out_item_t out_q, out_d;
  logic [2:0]           k_q, k_d;
  logic [2:0]           total;
  logic                 last;
  logic                 advance;
  logic [5:0]           sextet;
  logic [6:0]           ch;

  assign total   = job_i.nl ? ((job_i.nsym != 3'd0) ? 3'd5 : 3'd1) : 3'd4;
  assign last    = k_q == total - 3'd1;
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && job_valid_i && last;

  always_comb begin
    case (k_q[1:0])
      2'd0:    sextet = job_i.bits[23:18];
      2'd1:    sextet = job_i.bits[17:12];
      2'd2:    sextet = job_i.bits[11:6];
      default: sextet = job_i.bits[5:0];
    endcase
    if (job_i.nsym != 3'd0 && k_q < 3'(b64le_pkg::GroupChars)) begin
      ch = (k_q < job_i.nsym) ? b64le_pkg::sym64(sextet) : b64le_pkg::PadChar;
    end else begin
      ch = b64le_pkg::NlChar;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    k_d         = k_q;
    if (advance) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        out_d.out_char    = ch;
        out_d.last_of_run = last;
        k_d               = last ? 3'd0 : k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_mid_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != 3'd0 |-> job_valid_i) else $error("job left queue mid-emission");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_q.last_of_run)
    else $error("job retired without last marker");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 3'd4) else $error("character index out of range");

endmodule
